FILE: rtl/rv32_pkg.sv
`default_nettype none
package rv32_pkg;

    typedef struct packed {
        logic        operation;
        logic [11:0] load_address;
        logic [31:0] load_data;
    } in_t;

    typedef struct packed {
        logic [31:0]        fetched_pc;
        logic [31:0]        instruction_word;
        logic [1:0]         service_kind;
        logic signed [31:0] service_value;
        logic               halted;
    } out_t;

    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    localparam logic [1:0] CFG_DATA_START  = 2'd0;
    localparam logic [1:0] CFG_STACK_INIT  = 2'd1;
    localparam logic [1:0] CFG_GLOBAL_INIT = 2'd2;

    localparam logic [1:0] SVC_NONE  = 2'd0;
    localparam logic [1:0] SVC_INT   = 2'd1;
    localparam logic [1:0] SVC_STR   = 2'd2;
    localparam logic [1:0] SVC_EXIT  = 2'd3;

    localparam logic [31:0] A7_INT  = 32'd1;
    localparam logic [31:0] A7_STR  = 32'd4;
    localparam logic [31:0] A7_EXIT = 32'd10;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SW  = 3'd2;

    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_AND  = 4'd2;
    localparam logic [3:0] ALU_OR   = 4'd3;
    localparam logic [3:0] ALU_XOR  = 4'd4;
    localparam logic [3:0] ALU_SLT  = 4'd5;
    localparam logic [3:0] ALU_SLTU = 4'd6;
    localparam logic [3:0] ALU_SLL  = 4'd7;
    localparam logic [3:0] ALU_SRL  = 4'd8;
    localparam logic [3:0] ALU_SRA  = 4'd9;

    typedef struct packed {
        logic eq;
        logic lt;
        logic ltu;
    } alu_flags_t;

    function automatic logic [31:0] imm_i(input logic [31:0] ir);
        imm_i = {{20{ir[31]}}, ir[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] ir);
        imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] ir);
        imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] ir);
        imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    endfunction

    function automatic logic [31:0] imm_u(input logic [31:0] ir);
        imm_u = {ir[31:12], 12'h000};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rv32_alu.sv
`default_nettype none
module rv32_alu (
    input  wire logic [3:0]            op,
    input  wire logic [31:0]           a,
    input  wire logic [31:0]           b,
    output logic [31:0]                y,
    output rv32_pkg::alu_flags_t       flags
);
    import rv32_pkg::*;

    logic [32:0] diff;
    logic        lt_s;

    // one subtractor serves sub and the lt and ltu compares; eq is a separate equality test
    assign diff = {1'b0, a} - {1'b0, b};
    assign lt_s = (a[31] != b[31]) ? a[31] : diff[31];

    always_comb
    begin
        flags.eq  = (a == b);
        flags.lt  = lt_s;
        flags.ltu = diff[32];
        unique case (op)
            ALU_ADD:  y = a + b;
            ALU_SUB:  y = diff[31:0];
            ALU_AND:  y = a & b;
            ALU_OR:   y = a | b;
            ALU_XOR:  y = a ^ b;
            ALU_SLT:  y = {31'd0, lt_s};
            ALU_SLTU: y = {31'd0, diff[32]};
            ALU_SLL:  y = a << b[4:0];
            ALU_SRL:  y = a >> b[4:0];
            ALU_SRA:  y = 32'($signed(a) >>> b[4:0]);
            default:  y = a + b;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/rv32i_subset_core.sv
`default_nettype none
// Small RV32I core run one request at a time. A load request (operation 0)
// writes one word of the program/data memory and is done in its accept cycle.
// A step request (operation 1) runs one instruction: fetch, read of two
// registers, execute, an optional memory step (lb, lbu, lw and sb, which
// read the word, sb then merging its byte) and a next-pc/write-back step,
// held while the output stalls. A step at or past data_start registers its
// halted result on accept. The steps are set by the single memory port and
// the single register file read port, and every add, compare and shift goes
// through one shared ALU. The input stalls while a step is in flight and while
// a finished result waits on a stalled output. MEM_WORDS must be a power of
// two; byte addresses wrap modulo the memory size. Memory words are undefined
// until loaded. x2 and x3 start at stack_init and global_init and are
// reloaded whenever those registers are written.
module rv32i_subset_core #(
    parameter int MEM_WORDS = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire rv32_pkg::in_t    in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rv32_pkg::out_t        out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [13:0]      cfg_data
);
    import rv32_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_RS1   = 3'd2;
    localparam logic [2:0] S_RS2   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_MEM   = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [31:0] pc_reg, pc_next;
    logic [13:0] data_start_reg, stack_init_reg, global_init_reg;
    logic        out_valid_reg;
    logic [31:0] rf_vld_reg;
    logic        taken_reg, taken_next;

    // payload
    logic [31:0] ir_reg, a_reg, b_reg, res_reg, res_next;
    out_t        out_reg, out_next;
    logic        out_load;

    // word memory, one port, registered read
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] mem_q_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wd;

    // register file, one read port and one write port, registered read
    logic [31:0] rf [32];
    logic [31:0] rf_raw_reg, rf_dflt_reg, rf_q;
    logic        rf_hit_reg;
    logic [4:0]  rf_ra, rf_wa;
    logic        rf_we;
    logic [31:0] rf_wd;

    // shared ALU
    logic [3:0]  alu_op;
    logic [31:0] alu_a, alu_b, alu_y;
    alu_flags_t  alu_flags;

    // decode fields
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        is_ecall;
    logic        wr_en;
    logic        out_busy, accept, halt_now;
    logic [31:0] la32, byte_sel;
    logic [1:0]  lane;
    logic [7:0]  lbyte;
    logic [31:0] sb_word;
    logic [1:0]  svc_kind;
    logic        taken;

    rv32_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .y     (alu_y),
        .flags (alu_flags)
    );

    assign opc      = ir_reg[6:0];
    assign f3       = ir_reg[14:12];
    assign f7       = ir_reg[31:25];
    assign rd       = ir_reg[11:7];
    assign is_ecall = (mem_q_reg[6:0] == OPC_SYSTEM);

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_busy;
    assign accept    = in_valid && !in_stall;
    assign halt_now  = (pc_reg >= {18'd0, data_start_reg});
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign la32     = 32'(in_data.load_address);
    assign lane     = res_reg[1:0];
    assign byte_sel = mem_q_reg >> {lane, 3'b000};
    assign lbyte    = byte_sel[7:0];

    always_comb
    begin
        sb_word = mem_q_reg;
        unique case (lane)
            2'd0: sb_word[7:0]   = b_reg[7:0];
            2'd1: sb_word[15:8]  = b_reg[7:0];
            2'd2: sb_word[23:16] = b_reg[7:0];
            2'd3: sb_word[31:24] = b_reg[7:0];
            default: sb_word = mem_q_reg;
        endcase
    end

    // write enable of the decoded instruction, as the subset defines it
    always_comb
    begin
        wr_en = 1'b0;
        unique case (opc)
            OPC_OP:
                wr_en = (f7 == F7_ALT && f3 == F3_ADD) ||
                        (f7 == F7_BASE && f3 != F3_SLL && f3 != F3_SR);
            OPC_OPIMM:
                wr_en = (f3 == F3_ADD) || (f3 == F3_AND) || (f3 == F3_OR) ||
                        (f3 == F3_SLL && f7 == F7_BASE) ||
                        (f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT));
            OPC_AUIPC, OPC_LUI, OPC_JAL, OPC_JALR:
                wr_en = 1'b1;
            OPC_LOAD:
                wr_en = (f3 == F3_LB) || (f3 == F3_LBU) || (f3 == F3_LW);
            default:
                wr_en = 1'b0;
        endcase
    end

    // environment service from a7, which sits in a_reg for an ecall
    always_comb
    begin
        priority if (a_reg == A7_INT)
            svc_kind = SVC_INT;
        else if (a_reg == A7_STR)
            svc_kind = SVC_STR;
        else if (a_reg == A7_EXIT)
            svc_kind = SVC_EXIT;
        else
            svc_kind = SVC_NONE;
    end

    always_comb
    begin
        unique case (f3)
            F3_BEQ:  taken = alu_flags.eq;
            F3_BNE:  taken = !alu_flags.eq;
            F3_BLT:  taken = alu_flags.lt;
            F3_BGE:  taken = !alu_flags.lt;
            F3_BLTU: taken = alu_flags.ltu;
            F3_BGEU: taken = !alu_flags.ltu;
            default: taken = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        res_next   = res_reg;
        taken_next = taken_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        mem_addr   = pc_reg[AW+1:2];
        mem_we     = 1'b0;
        mem_wd     = in_data.load_data;
        rf_ra      = mem_q_reg[19:15];
        rf_we      = 1'b0;
        rf_wa      = rd;
        rf_wd      = res_reg;
        alu_op     = ALU_ADD;
        alu_a      = a_reg;
        alu_b      = b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.operation == OPER_LOAD) begin
                    // load request: write the word, no result
                    mem_addr = la32[AW-1:0];
                    mem_we   = 1'b1;
                end else if (accept && halt_now) begin
                    out_next = '{pc_reg, 32'd0, SVC_NONE, 32'sd0, 1'b1};
                    out_load = 1'b1;
                end else if (accept) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // ecall reads a7 then a0 in place of rs1 and rs2
                rf_ra      = is_ecall ? 5'd17 : mem_q_reg[19:15];
                state_next = S_RS1;
            end
            S_RS1:
            begin
                rf_ra      = (opc == OPC_SYSTEM) ? 5'd10 : ir_reg[24:20];
                state_next = S_RS2;
            end
            S_RS2:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_NEXT;
                unique case (opc)
                    OPC_OP:
                    begin
                        unique case (f3)
                            F3_ADD:  alu_op = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
                            F3_SLT:  alu_op = ALU_SLT;
                            F3_SLTU: alu_op = ALU_SLTU;
                            F3_XOR:  alu_op = ALU_XOR;
                            F3_OR:   alu_op = ALU_OR;
                            F3_AND:  alu_op = ALU_AND;
                            default: alu_op = ALU_ADD;
                        endcase
                    end
                    OPC_OPIMM:
                    begin
                        alu_b = imm_i(ir_reg);
                        unique case (f3)
                            F3_AND:  alu_op = ALU_AND;
                            F3_OR:   alu_op = ALU_OR;
                            F3_SLL:  alu_op = ALU_SLL;
                            F3_SR:   alu_op = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                            default: alu_op = ALU_ADD;
                        endcase
                    end
                    OPC_AUIPC:
                    begin
                        alu_a = pc_reg;
                        alu_b = imm_u(ir_reg);
                    end
                    OPC_LUI:
                    begin
                        alu_a = 32'd0;
                        alu_b = imm_u(ir_reg);
                    end
                    OPC_JAL:
                    begin
                        alu_a = pc_reg;
                        alu_b = 32'd4;
                    end
                    OPC_JALR:
                    begin
                        alu_b = imm_i(ir_reg);
                    end
                    OPC_LOAD:
                    begin
                        alu_b    = imm_i(ir_reg);
                        mem_addr = alu_y[AW+1:2];
                        if (wr_en)
                            state_next = S_MEM;
                    end
                    OPC_STORE:
                    begin
                        alu_b    = imm_s(ir_reg);
                        mem_addr = alu_y[AW+1:2];
                        mem_wd   = b_reg;
                        if (f3 == F3_SW)
                            mem_we = 1'b1;
                        else if (f3 == F3_SB)
                            state_next = S_MEM;
                    end
                    OPC_BRANCH:
                    begin
                        alu_op = ALU_SUB;
                    end
                    default:
                    begin
                        alu_op = ALU_ADD;
                    end
                endcase
                res_next   = alu_y;
                taken_next = (opc == OPC_BRANCH) && taken;
            end
            S_MEM:
            begin
                // byte lane from the address held in res_reg
                mem_addr   = res_reg[AW+1:2];
                state_next = S_NEXT;
                if (opc == OPC_STORE) begin
                    mem_wd = sb_word;
                    mem_we = 1'b1;
                end else if (f3 == F3_LB) begin
                    res_next = {{24{lbyte[7]}}, lbyte};
                end else if (f3 == F3_LBU) begin
                    res_next = {24'd0, lbyte};
                end else begin
                    res_next = mem_q_reg;
                end
            end
            S_NEXT:
            begin
                alu_a = pc_reg;
                if (opc == OPC_JAL)
                    alu_b = imm_j(ir_reg);
                else if (taken_reg)
                    alu_b = imm_b(ir_reg);
                else
                    alu_b = 32'd4;
                if (!out_busy) begin
                    state_next = S_IDLE;
                    out_load   = 1'b1;
                    out_next   = '{pc_reg, ir_reg, SVC_NONE, 32'sd0, 1'b0};
                    if (opc == OPC_SYSTEM && svc_kind != SVC_NONE) begin
                        out_next.service_kind  = svc_kind;
                        out_next.service_value = $signed(b_reg);
                    end
                    if (opc == OPC_SYSTEM && svc_kind == SVC_EXIT)
                        pc_next = {18'd0, data_start_reg};
                    else if (opc == OPC_JALR)
                        pc_next = {res_reg[31:1], 1'b0};
                    else
                        pc_next = alu_y;
                    rf_we = wr_en && (rd != 5'd0);
                    rf_wd = (opc == OPC_JALR) ? alu_y : res_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration reloads x2 or x3; the user must write it only while idle, which the block does not enforce
        if (cfg_valid && cfg_index == CFG_STACK_INIT) begin
            rf_we = 1'b1;
            rf_wa = 5'd2;
            rf_wd = {18'd0, cfg_data};
        end else if (cfg_valid && cfg_index == CFG_GLOBAL_INIT) begin
            rf_we = 1'b1;
            rf_wa = 5'd3;
            rf_wd = {18'd0, cfg_data};
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        mem_q_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_wa] <= rf_wd;
        rf_raw_reg <= rf[rf_ra];
    end

    // an entry never written reads its reset value
    always_ff @(posedge clk)
    begin
        rf_hit_reg <= rf_vld_reg[rf_ra];
        if (rf_ra == 5'd2)
            rf_dflt_reg <= {18'd0, stack_init_reg};
        else if (rf_ra == 5'd3)
            rf_dflt_reg <= {18'd0, global_init_reg};
        else
            rf_dflt_reg <= 32'd0;
    end

    assign rf_q = rf_hit_reg ? rf_raw_reg : rf_dflt_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
            ir_reg <= mem_q_reg;
        if (state_reg == S_RS1)
            a_reg <= rf_q;
        if (state_reg == S_RS2)
            b_reg <= rf_q;
        res_reg <= res_next;
        if (out_load)
            out_reg <= out_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            pc_reg          <= 32'd0;
            data_start_reg  <= 14'd8192;
            stack_init_reg  <= 14'd16380;
            global_init_reg <= 14'd6144;
            out_valid_reg   <= 1'b0;
            rf_vld_reg      <= 32'd0;
            taken_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            taken_reg <= taken_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (rf_we)
                rf_vld_reg[rf_wa] <= 1'b1;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_DATA_START:  data_start_reg  <= cfg_data;
                    CFG_STACK_INIT:  stack_init_reg  <= cfg_data;
                    CFG_GLOBAL_INIT: global_init_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(in_valid && !in_stall))
        else $error("request accepted while a step is in flight");

    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_vld_reg[0])
        else $error("x0 was written");

    a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT && !out_busy) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished step left no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_reg))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
